// File: rtl/ezrpd_pkg.sv
// Package for the escaped zero-run payload decoder: codes, result type and
// small character helpers. No dependencies.
`default_nettype none

package ezrpd_pkg;

  // Field widths
  localparam int unsigned CharW    = 8;
  localparam int unsigned CountW   = 17;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned RunW     = 64;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  // Largest zero run accepted
  localparam logic [RunW-1:0] MaxRun = 64'd65536;

  // Results per input beat and depth of the result queue
  localparam int unsigned MaxRes = 3;
  localparam int unsigned QDepth = 4;

  // Characters of the escape syntax
  localparam logic [CharW-1:0] CharBackslash = 8'h5C;
  localparam logic [CharW-1:0] CharN         = 8'h6E;
  localparam logic [CharW-1:0] CharT         = 8'h74;
  localparam logic [CharW-1:0] CharX         = 8'h78;
  localparam logic [CharW-1:0] CharZ         = 8'h7A;
  localparam logic [CharW-1:0] Char0         = 8'h30;
  localparam logic [CharW-1:0] Char9         = 8'h39;
  localparam logic [CharW-1:0] ByteNewline   = 8'd10;
  localparam logic [CharW-1:0] ByteTab       = 8'd9;

  // Decoder phase, one-hot
  typedef enum logic [5:0] {
    PH_NORMAL = 6'b000001,
    PH_ESC    = 6'b000010,
    PH_HEX_HI = 6'b000100,
    PH_HEX_LO = 6'b001000,
    PH_ZSTART = 6'b010000,
    PH_RUN    = 6'b100000
  } phase_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_DATA      = 3'd0,
    ST_END       = 3'd1,
    ST_SHORT_HEX = 3'd2,
    ST_BAD_HEX   = 3'd3,
    ST_BAD_COUNT = 3'd4,
    ST_TOO_LARGE = 3'd5
  } status_e;

  // One result item
  typedef struct packed {
    logic [CharW-1:0]  data;
    logic [CountW-1:0] count;
    status_e           status;
    logic              last;
  } result_t;

  // Hex digit value; bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/escaped_zero_run_payload_decoder.sv
// Escaped zero-run payload decoder, top level.
// Depends on ezrpd_pkg.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata[7:0] in_char, tlast in_last
// m_axis    out  m_axis_tvalid/tready      tdata[27:0] byte,count,status; tlast
// cfg       in   cfg_we_i (no wait)        cfg_wdata_i rle_mode
//
// One input beat is decoded per cycle: input register, one pass of decode
// logic, then a four-entry result queue that drains one beat per cycle while ready.
// A beat yields zero to three results; sustained rate is one beat per cycle
// while each beat yields at most one result, bounded by the one output port.
// Input is taken while the queue holds at most one result, so a result can
// wait on m_axis_tready while the next beat is decoded.
// Reset (rst_ni low, asynchronous) clears the phase, run state and queue.
`default_nettype none

module escaped_zero_run_payload_decoder (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_wdata_i,
  // input stream
  input  wire logic                               s_axis_tvalid_i,
  output      logic                               s_axis_tready_o,
  input  wire logic [ezrpd_pkg::InDataW-1:0]      s_axis_tdata_i,  // [7:0] in_char
  input  wire logic                               s_axis_tlast_i,  // in_last
  // result stream
  output      logic                               m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [7:0] out_byte, [24:8] out_count, [27:25] out_status, [31:28] zero
  output      logic [ezrpd_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output      logic                               m_axis_tlast_o   // out_last
);

  // Input register
  logic                             in_valid_q, in_valid_d;
  logic [ezrpd_pkg::CharW-1:0]      in_char_q;
  logic                             in_last_q;
  logic                             in_take;
  logic                             advance;

  // Decoder state
  logic                             rle_mode_q;
  ezrpd_pkg::phase_e                phase_q, phase_d;
  logic [3:0]                       hex_high_q, hex_high_d;
  logic                             hex_invalid_q, hex_invalid_d;
  logic [ezrpd_pkg::RunW-1:0]       run_value_q, run_value_d;
  logic                             run_ovf_q, run_ovf_d;
  logic                             run_octal_q, run_octal_d;
  logic                             run_bad_q, run_bad_d;
  logic                             discard_q, discard_d;

  // Decode results
  ezrpd_pkg::result_t               res [ezrpd_pkg::MaxRes];
  logic [1:0]                       nres;

  // Result queue, entry 0 is the head
  ezrpd_pkg::result_t               q_q [ezrpd_pkg::QDepth];
  ezrpd_pkg::result_t               q_d [ezrpd_pkg::QDepth];
  logic [2:0]                       count_q, count_d;
  logic [2:0]                       base;
  logic                             pop;

  // Handshakes
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign advance         = in_valid_q && (count_q <= 3'd1);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata_i[ezrpd_pkg::CharW-1:0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Decode one character
  always_comb begin
    logic [ezrpd_pkg::CharW-1:0] c;
    logic                        lst;
    logic [4:0]                  hexv;
    logic                        dig;
    logic [3:0]                  d;
    logic [67:0]                 mul;
    logic [67:0]                 sum;
    logic                        stop;
    logic                        failv;
    ezrpd_pkg::status_e          fail_st;

    c    = in_char_q;
    lst  = in_last_q;
    hexv = ezrpd_pkg::hex_digit(c);
    dig  = (c >= ezrpd_pkg::Char0) && (c <= ezrpd_pkg::Char9);
    d    = c[3:0];
    // next run value: times 8 or times 10, plus digit
    mul  = run_octal_q ? {1'b0, run_value_q, 3'b000}
                       : ({1'b0, run_value_q, 3'b000} + {3'b000, run_value_q, 1'b0});
    sum  = mul + {64'd0, d};

    for (int i = 0; i < ezrpd_pkg::MaxRes; i++) begin
      res[i] = '{data: '0, count: '0, status: ezrpd_pkg::ST_DATA, last: 1'b0};
    end
    nres          = 2'd0;
    phase_d       = phase_q;
    hex_high_d    = hex_high_q;
    hex_invalid_d = hex_invalid_q;
    run_value_d   = run_value_q;
    run_ovf_d     = run_ovf_q;
    run_octal_d   = run_octal_q;
    run_bad_d     = run_bad_q;
    discard_d     = discard_q;
    stop          = 1'b0;
    failv         = 1'b0;
    fail_st       = ezrpd_pkg::ST_DATA;

    if (discard_q) begin
      // drop the rest of a failed payload
      if (lst) begin
        discard_d = 1'b0;
      end
      stop = 1'b1;
    end else if (phase_q == ezrpd_pkg::PH_ZSTART || phase_q == ezrpd_pkg::PH_RUN) begin
      // digit run
      if (dig) begin
        if (phase_q == ezrpd_pkg::PH_ZSTART) begin
          run_octal_d = (d == 4'd0);
          run_value_d = {60'd0, d};
          phase_d     = ezrpd_pkg::PH_RUN;
        end else begin
          if (run_octal_q && d >= 4'd8) begin
            run_bad_d = 1'b1;
          end
          if (!run_ovf_q) begin
            if (sum[67:64] != 4'd0) begin
              run_ovf_d = 1'b1;
            end else begin
              run_value_d = sum[63:0];
            end
          end
        end
        stop = !lst;
      end
      // close the run at a non-digit or at the final character
      if (!dig || lst) begin
        if (phase_d == ezrpd_pkg::PH_ZSTART || run_bad_d || run_ovf_d) begin
          failv   = 1'b1;
          fail_st = ezrpd_pkg::ST_BAD_COUNT;
        end else if (run_value_d > ezrpd_pkg::MaxRun) begin
          failv   = 1'b1;
          fail_st = ezrpd_pkg::ST_TOO_LARGE;
        end else if (run_value_d != '0) begin
          res[nres] = '{data: '0, count: run_value_d[ezrpd_pkg::CountW-1:0],
                        status: ezrpd_pkg::ST_DATA, last: 1'b0};
          nres = nres + 2'd1;
        end
        run_value_d = '0;
        run_ovf_d   = 1'b0;
        run_octal_d = 1'b0;
        run_bad_d   = 1'b0;
        phase_d     = ezrpd_pkg::PH_NORMAL;
        if (failv) begin
          stop = 1'b1;
        end else if (dig) begin
          res[nres] = '{data: '0, count: '0, status: ezrpd_pkg::ST_END, last: 1'b1};
          nres = nres + 2'd1;
          stop = 1'b1;
        end
      end
    end

    // character decode
    if (!stop) begin
      case (phase_d)
        ezrpd_pkg::PH_ESC: begin
          phase_d = ezrpd_pkg::PH_NORMAL;
          if (c == ezrpd_pkg::CharX) begin
            if (lst) begin
              failv   = 1'b1;
              fail_st = ezrpd_pkg::ST_SHORT_HEX;
            end else begin
              phase_d = ezrpd_pkg::PH_HEX_HI;
            end
          end else if (c == ezrpd_pkg::CharZ && rle_mode_q) begin
            run_value_d = '0;
            run_ovf_d   = 1'b0;
            run_octal_d = 1'b0;
            run_bad_d   = 1'b0;
            phase_d     = ezrpd_pkg::PH_ZSTART;
            // empty run at end of payload
            if (lst) begin
              failv   = 1'b1;
              fail_st = ezrpd_pkg::ST_BAD_COUNT;
            end
          end else if (c == ezrpd_pkg::CharN && !rle_mode_q) begin
            res[nres] = '{data: ezrpd_pkg::ByteNewline, count: 17'd1,
                          status: ezrpd_pkg::ST_DATA, last: 1'b0};
            nres = nres + 2'd1;
          end else if (c == ezrpd_pkg::CharT && !rle_mode_q) begin
            res[nres] = '{data: ezrpd_pkg::ByteTab, count: 17'd1,
                          status: ezrpd_pkg::ST_DATA, last: 1'b0};
            nres = nres + 2'd1;
          end else begin
            res[nres] = '{data: c, count: 17'd1, status: ezrpd_pkg::ST_DATA, last: 1'b0};
            nres = nres + 2'd1;
          end
        end
        ezrpd_pkg::PH_HEX_HI: begin
          hex_high_d    = hexv[3:0];
          hex_invalid_d = hexv[4];
          if (lst) begin
            failv   = 1'b1;
            fail_st = ezrpd_pkg::ST_SHORT_HEX;
          end else begin
            phase_d = ezrpd_pkg::PH_HEX_LO;
          end
        end
        ezrpd_pkg::PH_HEX_LO: begin
          if (hex_invalid_q || hexv[4]) begin
            failv   = 1'b1;
            fail_st = ezrpd_pkg::ST_BAD_HEX;
          end else begin
            res[nres] = '{data: {hex_high_q, hexv[3:0]}, count: 17'd1,
                          status: ezrpd_pkg::ST_DATA, last: 1'b0};
            nres = nres + 2'd1;
            hex_high_d    = 4'd0;
            hex_invalid_d = 1'b0;
            phase_d       = ezrpd_pkg::PH_NORMAL;
          end
        end
        default: begin
          phase_d = ezrpd_pkg::PH_NORMAL;
          if (c == ezrpd_pkg::CharBackslash) begin
            // trailing backslash is literal
            if (lst) begin
              res[nres] = '{data: ezrpd_pkg::CharBackslash, count: 17'd1,
                            status: ezrpd_pkg::ST_DATA, last: 1'b0};
              nres = nres + 2'd1;
            end else begin
              phase_d = ezrpd_pkg::PH_ESC;
            end
          end else begin
            res[nres] = '{data: c, count: 17'd1, status: ezrpd_pkg::ST_DATA, last: 1'b0};
            nres = nres + 2'd1;
          end
        end
      endcase
      if (!failv && lst) begin
        phase_d = ezrpd_pkg::PH_NORMAL;
        res[nres] = '{data: '0, count: '0, status: ezrpd_pkg::ST_END, last: 1'b1};
        nres = nres + 2'd1;
      end
    end

    // error closes the payload
    if (failv) begin
      res[nres] = '{data: '0, count: '0, status: fail_st, last: 1'b1};
      nres = nres + 2'd1;
      phase_d       = ezrpd_pkg::PH_NORMAL;
      hex_high_d    = 4'd0;
      hex_invalid_d = 1'b0;
      run_value_d   = '0;
      run_ovf_d     = 1'b0;
      run_octal_d   = 1'b0;
      run_bad_d     = 1'b0;
      discard_d     = !lst;
    end
  end

  // Decoder state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_mode_q    <= 1'b0;
      phase_q       <= ezrpd_pkg::PH_NORMAL;
      hex_high_q    <= 4'd0;
      hex_invalid_q <= 1'b0;
      run_value_q   <= '0;
      run_ovf_q     <= 1'b0;
      run_octal_q   <= 1'b0;
      run_bad_q     <= 1'b0;
      discard_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rle_mode_q <= cfg_wdata_i;
      end
      if (advance) begin
        phase_q       <= phase_d;
        hex_high_q    <= hex_high_d;
        hex_invalid_q <= hex_invalid_d;
        run_value_q   <= run_value_d;
        run_ovf_q     <= run_ovf_d;
        run_octal_q   <= run_octal_d;
        run_bad_q     <= run_bad_d;
        discard_q     <= discard_d;
      end
    end
  end

  // Result queue: shift on pop, new results land behind the survivors
  assign base = count_q - {2'b00, pop};

  always_comb begin
    logic [2:0] idx;
    for (int j = 0; j < ezrpd_pkg::QDepth; j++) begin
      idx = 3'(j) - base;
      if (advance && idx < {1'b0, nres}) begin
        q_d[j] = res[idx[1:0]];
      end else if (pop && j < ezrpd_pkg::QDepth - 1) begin
        q_d[j] = q_q[(j + 1) % ezrpd_pkg::QDepth];
      end else begin
        q_d[j] = q_q[j];
      end
    end
    count_d = advance ? (base + {1'b0, nres}) : base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ezrpd_pkg::QDepth; j++) begin
      q_q[j] <= q_d[j];
    end
  end

  // Output beat from the queue head
  assign m_axis_tvalid_o = (count_q != 3'd0);
  assign m_axis_tdata_o  = {4'b0000, q_q[0].status, q_q[0].count, q_q[0].data};
  assign m_axis_tlast_o  = q_q[0].last;

endmodule

`default_nettype wire

// File: rtl/ezrpd_checker.sv
// Port-level checks for the escaped zero-run payload decoder, bound to the
// top level. Depends on ezrpd_pkg.
`default_nettype none

module ezrpd_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [ezrpd_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                           m_axis_tlast_o
);

  logic [2:0] st;
  assign st = m_axis_tdata_o[27:25];

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // Data beats carry a nonzero count and never close the payload
  a_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st == ezrpd_pkg::ST_DATA |->
      m_axis_tdata_o[24:8] != 17'd0 && !m_axis_tlast_o)
    else $error("bad data beat");

  // End and error beats are zero and close the payload
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && st != ezrpd_pkg::ST_DATA |->
      m_axis_tdata_o[24:0] == 25'd0 && m_axis_tlast_o)
    else $error("bad closing beat");

  // Status is a defined code and pad bits are zero
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (st == ezrpd_pkg::ST_DATA || st == ezrpd_pkg::ST_END ||
       st == ezrpd_pkg::ST_SHORT_HEX || st == ezrpd_pkg::ST_BAD_HEX ||
       st == ezrpd_pkg::ST_BAD_COUNT || st == ezrpd_pkg::ST_TOO_LARGE) &&
      m_axis_tdata_o[31:28] == 4'd0)
    else $error("undefined status or pad bits");

endmodule

bind escaped_zero_run_payload_decoder ezrpd_checker u_ezrpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// File: test/payload_decode_checker.sv
// Checker for the escaped zero-run payload decoder: watches the config port and
// both stream channels, predicts every result beat and compares it field by field.
// Depends on ezrpd_pkg.

module payload_decode_checker
  import ezrpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,   // [7:0] in_char
  input  logic                s_tlast_i,   // in_last
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // [7:0] out_byte, [24:8] out_count, [27:25] out_status, [31:28] zero
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tlast_i,   // out_last
  output int                  mismatch_count_o,
  output int                  pending_o
);

  // Predicted decoder state
  phase_e      dec_phase;
  logic [3:0]  hex_hi;
  logic        hex_bad;
  logic [63:0] run_val;
  logic        run_ovf;
  logic        run_oct;
  logic        run_bad;
  logic        discard;
  logic        rle_mode;

  // Decoded results not yet seen on the output
  result_t     decoded_results[$];
  int          mismatches;
  int          pending;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  function automatic void emit(input logic [7:0] data, input logic [CountW-1:0] count,
                               input status_e status, input logic lst);
    result_t r;
    r.data   = data;
    r.count  = count;
    r.status = status;
    r.last   = lst;
    decoded_results.insert(decoded_results.size(), r);
  endfunction

  // 16 in the top bit marks a character that is no hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= Char0 && c <= Char9) return 5'(c - Char0);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'h10;
  endfunction

  function automatic void clear_run();
    run_val = '0;
    run_ovf = 1'b0;
    run_oct = 1'b0;
    run_bad = 1'b0;
  endfunction

  // Error result; the rest of the payload is dropped unless this was its end
  function automatic void abort(input status_e status, input logic lst);
    emit(8'h00, '0, status, 1'b1);
    dec_phase = PH_NORMAL;
    hex_hi    = '0;
    hex_bad   = 1'b0;
    clear_run();
    discard   = !lst;
  endfunction

  function automatic void add_run_digit(input logic [3:0] d);
    logic [71:0] acc;
    if (dec_phase == PH_ZSTART) begin
      run_oct   = (d == 4'd0);
      run_val   = 64'(d);
      dec_phase = PH_RUN;
      return;
    end
    if (run_oct && d >= 4'd8) run_bad = 1'b1;
    if (run_ovf) return;
    acc = {8'h00, run_val} * (run_oct ? 72'd8 : 72'd10) + 72'(d);
    if (acc[71:64] != 8'h00) begin
      run_ovf = 1'b1;
    end else begin
      run_val = acc[63:0];
    end
  endfunction

  // Closes a digit run; ST_DATA means no error
  function automatic status_e close_run();
    status_e err;
    err = ST_DATA;
    if (dec_phase == PH_ZSTART || run_bad || run_ovf) begin
      err = ST_BAD_COUNT;
    end else if (run_val > MaxRun) begin
      err = ST_TOO_LARGE;
    end else if (run_val != 0) begin
      emit(8'h00, run_val[CountW-1:0], ST_DATA, 1'b0);
    end
    clear_run();
    dec_phase = PH_NORMAL;
    return err;
  endfunction

  // Predicts the results of one input beat
  function automatic void decode_char(input logic [7:0] c, input logic lst);
    status_e    err;
    logic [4:0] hv;
    if (discard) begin
      if (lst) discard = 1'b0;
      return;
    end
    // a digit run goes on, or closes before the character is decoded
    if (dec_phase == PH_ZSTART || dec_phase == PH_RUN) begin
      if (c >= Char0 && c <= Char9) begin
        add_run_digit(4'(c - Char0));
        if (!lst) return;
        err = close_run();
        if (err != ST_DATA) begin
          abort(err, 1'b1);
        end else begin
          emit(8'h00, '0, ST_END, 1'b1);
        end
        return;
      end
      err = close_run();
      if (err != ST_DATA) begin
        abort(err, lst);
        return;
      end
    end
    case (dec_phase)
      PH_ESC: begin
        dec_phase = PH_NORMAL;
        if (c == CharX) begin
          if (lst) begin
            abort(ST_SHORT_HEX, 1'b1);
            return;
          end
          dec_phase = PH_HEX_HI;
        end else if (c == CharZ && rle_mode) begin
          clear_run();
          dec_phase = PH_ZSTART;
          if (lst) begin
            err = close_run();
            abort(err, 1'b1);
            return;
          end
        end else if (c == CharN && !rle_mode) begin
          emit(ByteNewline, 17'd1, ST_DATA, 1'b0);
        end else if (c == CharT && !rle_mode) begin
          emit(ByteTab, 17'd1, ST_DATA, 1'b0);
        end else begin
          emit(c, 17'd1, ST_DATA, 1'b0);
        end
      end
      PH_HEX_HI: begin
        hv      = hex_value(c);
        hex_hi  = hv[3:0];
        hex_bad = hv[4];
        if (lst) begin
          abort(ST_SHORT_HEX, 1'b1);
          return;
        end
        dec_phase = PH_HEX_LO;
      end
      PH_HEX_LO: begin
        hv = hex_value(c);
        if (hex_bad || hv[4]) begin
          abort(ST_BAD_HEX, lst);
          return;
        end
        emit({hex_hi, hv[3:0]}, 17'd1, ST_DATA, 1'b0);
        hex_hi    = '0;
        hex_bad   = 1'b0;
        dec_phase = PH_NORMAL;
      end
      default: begin
        dec_phase = PH_NORMAL;
        if (c == CharBackslash) begin
          // a trailing backslash stands for itself
          if (lst) begin
            emit(CharBackslash, 17'd1, ST_DATA, 1'b0);
          end else begin
            dec_phase = PH_ESC;
          end
        end else begin
          emit(c, 17'd1, ST_DATA, 1'b0);
        end
      end
    endcase
    if (lst) begin
      dec_phase = PH_NORMAL;
      emit(8'h00, '0, ST_END, 1'b1);
    end
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(input logic [OutDataW-1:0] tdata, input logic tlast);
    result_t want;
    if (decoded_results.size() == 0) begin
      $error("result beat with nothing expected: tdata 0x%08h tlast %0b", tdata, tlast);
      mismatches++;
      return;
    end
    want = decoded_results.pop_front();
    compare_field("out_byte", want.data, tdata[7:0]);
    compare_field("out_count", want.count, tdata[24:8]);
    compare_field("out_status", want.status, tdata[27:25]);
    compare_field("out_last", want.last, tlast);
    compare_field("tdata pad", 0, tdata[31:28]);
  endfunction

  // Sample both channels and the config port at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_phase = PH_NORMAL;
      hex_hi    = '0;
      hex_bad   = 1'b0;
      clear_run();
      discard   = 1'b0;
      rle_mode  = 1'b0;
      decoded_results.delete();
      mismatches = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) decode_char(s_tdata_i[7:0], s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_result(m_tdata_i, m_tlast_i);
      if (cfg_we_i) rle_mode = cfg_wdata_i;
    end
    pending = decoded_results.size();
  end

endmodule

// File: test/tb_escaped_zero_run_payload_decoder.sv
// Testbench top for the escaped zero-run payload decoder: clock, reset, payload
// stimulus with random gaps and stalls, mode writes, watchdog and verdict.
// Depends on ezrpd_pkg, escaped_zero_run_payload_decoder and payload_decode_checker.

module tb_escaped_zero_run_payload_decoder;
  import ezrpd_pkg::*;

  localparam int PhaseItems    = 65;
  localparam int RandomItems   = 225;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 1000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                s_tlast   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  int                  mismatch_count;
  int                  pending;
  logic [7:0]          payload[$];
  logic                quiet     = 1'b0;
  logic                mode_now  = 1'b0;
  int                  items_sent = 0;
  int                  switch_at  = -1;
  int                  phase_no   = 0;
  int                  idle_cycles = 0;

  escaped_zero_run_payload_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  payload_decode_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .s_tlast_i        (s_tlast),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tlast_i        (m_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side stalls with a probability of about 12 percent outside the quiet stretch
  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 12);
  end

  // Watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("escaped_zero_run_payload_decoder test failed");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid still high
  task automatic send_char(input logic [7:0] c, input logic lst);
    while (!quiet && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Stop input, wait for all predicted results, then let the pipeline empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic reconfigure(input logic m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    mode_now  = m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Phase switches may fall inside a payload, so the mode can change mid-payload
  task automatic send_payload();
    for (int i = 0; i < payload.size(); i++) begin
      if (items_sent == switch_at) begin
        phase_no++;
        quiet = (phase_no == 2);
        reconfigure(!mode_now);
        switch_at += PhaseItems;
      end
      send_char(payload[i], i == payload.size() - 1);
    end
  endtask

  // Appends one character to the payload
  function automatic void add_char(input logic [7:0] c);
    payload.insert(payload.size(), c);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void push_decimal(input int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(Char0 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) add_char(digits[i]);
  endfunction

  // Mostly a valid hex digit in either case, otherwise any byte
  function automatic logic [7:0] hex_char();
    int k;
    if ($urandom_range(99) < 12) return 8'($urandom_range(255));
    k = $urandom_range(15);
    if (k < 10) return Char0 + 8'(k);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(k - 10);
  endfunction

  initial begin
    int stop_at;
    int pick;
    int r;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Raw mode: byte extremes, newline, tab, hex, trailing backslash
    payload.delete();
    add_char(8'h00);
    add_text("\\n\\t\\xaF");
    add_char(8'hFF);
    add_text("\\");
    send_payload();
    // Payload ends on the x
    payload.delete();
    add_text("\\x");
    send_payload();
    // Bad hex digit, then the rest of the payload is dropped
    payload.delete();
    add_text("\\xg1a");
    send_payload();

    // Run mode: octal run closed by an escape, then an 8 in an octal run
    reconfigure(1'b1);
    payload.delete();
    add_text("\\z012\\z08");
    send_payload();

    // Random payloads in phases of alternating mode, one without gaps
    stop_at   = items_sent + RandomItems;
    switch_at = items_sent + PhaseItems;
    while (items_sent < stop_at) begin
      payload.delete();
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          add_char(8'($urandom_range(255)));
        end else if (pick < 50) begin
          add_char(CharBackslash);
          case ($urandom_range(3))
            0:       add_char(CharN);
            1:       add_char(CharT);
            default: add_char(8'($urandom_range(255)));
          endcase
        end else if (pick < 70) begin
          add_char(CharBackslash);
          add_char(CharX);
          add_char(hex_char());
          add_char(hex_char());
        end else if (pick < 95) begin
          add_char(CharBackslash);
          add_char(CharZ);
          r = $urandom_range(99);
          if (r < 10) begin
            // empty run
          end else if (r < 20) begin
            add_char(Char0);
          end else if (r < 45) begin
            push_decimal($urandom_range(1, 300));
          end else if (r < 65) begin
            // octal run, sometimes with an 8 or 9 at its end
            add_char(Char0);
            repeat ($urandom_range(1, 4)) add_char(Char0 + 8'($urandom_range(7)));
            if (r >= 58) add_char(Char0 + 8'($urandom_range(8, 9)));
          end else if (r < 80) begin
            case ($urandom_range(3))
              0:       push_decimal(65535);
              1:       push_decimal(65536);
              2:       push_decimal(65537);
              default: push_decimal($urandom_range(1000, 99999));
            endcase
          end else if (r < 88) begin
            // 21 digits overflow 64 bits
            add_char(Char0 + 8'($urandom_range(1, 9)));
            repeat (20) add_char(Char0 + 8'($urandom_range(9)));
          end else begin
            push_decimal($urandom_range(1, 9));
          end
        end else begin
          add_char(CharBackslash);
        end
      end
      send_payload();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("escaped_zero_run_payload_decoder test passed");
    end else begin
      $display("escaped_zero_run_payload_decoder test failed");
    end
    $finish;
  end

endmodule
